// ===== design/combination_enumerator_top_defines.svh =====
// assertion macros shared by the combination enumerator rtl
// no dependencies; included by modules that carry assertions
`ifndef COMBINATION_ENUMERATOR_TOP_DEFINES_SVH
`define COMBINATION_ENUMERATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CEN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("cen assertion failed");

// next-cycle implication, disabled during reset
`define CEN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("cen assertion failed");

`endif

// ===== design/cen_pkg.sv =====
// shared constants, types and register codes of the combination enumerator
// no dependencies; used by the alu and the top level of the block
`timescale 1ns / 1ps
`default_nettype none

package cen_pkg;

  localparam int MAX_PICK      = 16;
  localparam int VALUE_BITS    = 6;
  localparam int IDX_BITS      = $clog2(MAX_PICK);
  localparam int LIM_BITS      = VALUE_BITS + 1;
  localparam int N_BITS        = 6;
  localparam int K_BITS        = 5;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 6;

  localparam logic [N_BITS-1:0] SET_SIZE_RST   = N_BITS'(4);
  localparam logic [K_BITS-1:0] PICK_COUNT_RST = K_BITS'(2);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SET_SIZE   = 1'b0,
    CFG_PICK_COUNT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                  we;
    logic [IDX_BITS-1:0]   addr;
    logic [VALUE_BITS-1:0] data;
  } wr_req_t;

endpackage

`default_nettype wire

// ===== design/cen_store.sv =====
// generic ram with one write port and one registered read port
// no dependencies; width and depth are set by parameters, a same-address read returns write data
`timescale 1ns / 1ps
`default_nettype none

module cen_store #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/cen_alu.sv =====
// shared incrementer and limit compare used by load, scan and refill steps
// depends on cen_pkg
`timescale 1ns / 1ps
`default_nettype none

module cen_alu (
  input  wire logic [cen_pkg::VALUE_BITS-1:0] operand_i,
  input  wire logic [cen_pkg::N_BITS-1:0]     set_size_i,
  input  wire logic [cen_pkg::K_BITS-1:0]     pick_count_i,
  input  wire logic [cen_pkg::IDX_BITS-1:0]   idx_i,
  output logic      [cen_pkg::VALUE_BITS-1:0] inc_o,
  output logic                                below_o
);

  logic [cen_pkg::LIM_BITS-1:0] limit;

  // limit for position idx is n - k + 1 + idx
  assign limit   = cen_pkg::LIM_BITS'(set_size_i) - cen_pkg::LIM_BITS'(pick_count_i)
                 + cen_pkg::LIM_BITS'(idx_i) + cen_pkg::LIM_BITS'(1);
  assign below_o = cen_pkg::LIM_BITS'(operand_i) < limit;
  assign inc_o   = operand_i + cen_pkg::VALUE_BITS'(1);

endmodule

`default_nettype wire

// ===== design/combination_enumerator_top.sv =====
// top level of the lexicographic combination enumerator: sequencer and output register
// depends on cen_pkg, cen_store, cen_alu and combination_enumerator_top_defines.svh
//
// channel   dir  handshake                 payload
// in        in   in_valid_i / in_ready_o   restart_i
// out       out  out_valid_o / out_ready_i element_o, last_element_o, exhausted_o
// cfg       in   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// restart: the load step writes 1..k into the store, then the emit step sends each element
// next: a right-to-left scan finds the position to increment and a tail refill follows, then emits
// exhausted: one marked transaction, sent directly from idle, or when a full scan finds no successor
// one request at a time, in_ready_o high only in idle; the store write port sets the pace
// output stalls hold the sequencer in its emit or exhausted step; reset needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none
`include "combination_enumerator_top_defines.svh"

module combination_enumerator_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               restart_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic      [cen_pkg::VALUE_BITS-1:0]     element_o,
  output logic                                    last_element_o,
  output logic                                    exhausted_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [cen_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [cen_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_FILL,
    ST_EMIT,
    ST_EXH
  } state_e;

  state_e                         state_q, state_d;
  logic [cen_pkg::IDX_BITS-1:0]   idx_q, idx_d;
  logic [cen_pkg::VALUE_BITS-1:0] run_q, run_d;
  logic                           started_q, started_d;
  logic                           finished_q, finished_d;
  logic [cen_pkg::N_BITS-1:0]     set_size_q, set_size_d;
  logic [cen_pkg::K_BITS-1:0]     pick_count_q, pick_count_d;
  logic                           out_valid_q, out_valid_d;
  logic [cen_pkg::VALUE_BITS-1:0] element_q, element_d;
  logic                           last_q, last_d;
  logic                           exh_q, exh_d;

  cen_pkg::wr_req_t               wr;
  logic [cen_pkg::VALUE_BITS-1:0] rd_data;
  logic [cen_pkg::VALUE_BITS-1:0] alu_operand;
  logic [cen_pkg::VALUE_BITS-1:0] alu_inc;
  logic                           alu_below;
  logic [cen_pkg::IDX_BITS-1:0]   k_last;
  logic                           bad_cfg;
  logic                           slot_free;
  logic                           in_accept;

  // read address is the next index so the entry is ready in the cycle that uses it
  cen_store #(
    .WIDTH (cen_pkg::VALUE_BITS),
    .DEPTH (cen_pkg::MAX_PICK)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (idx_d),
    .rdata_o (rd_data)
  );

  cen_alu u_alu (
    .operand_i    (alu_operand),
    .set_size_i   (set_size_q),
    .pick_count_i (pick_count_q),
    .idx_i        (idx_q),
    .inc_o        (alu_inc),
    .below_o      (alu_below)
  );

  assign k_last    = cen_pkg::IDX_BITS'(pick_count_q - cen_pkg::K_BITS'(1));
  assign bad_cfg   = (pick_count_q == '0)
                  || (cen_pkg::N_BITS'(pick_count_q) > set_size_q)
                  || (pick_count_q > cen_pkg::K_BITS'(cen_pkg::MAX_PICK));
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    case (state_q)
      ST_LOAD: alu_operand = cen_pkg::VALUE_BITS'(idx_q);
      ST_FILL: alu_operand = run_q;
      default: alu_operand = rd_data;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    run_d        = run_q;
    started_d    = started_q;
    finished_d   = finished_q;
    set_size_d   = set_size_q;
    pick_count_d = pick_count_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    element_d    = element_q;
    last_d       = last_q;
    exh_d        = exh_q;
    wr.we        = 1'b0;
    wr.addr      = idx_q;
    wr.data      = alu_inc;

    if (cfg_we_i) begin
      unique case (cen_pkg::cfg_reg_e'(cfg_idx_i))
        cen_pkg::CFG_SET_SIZE:   set_size_d   = cfg_data_i[cen_pkg::N_BITS-1:0];
        cen_pkg::CFG_PICK_COUNT: pick_count_d = cfg_data_i[cen_pkg::K_BITS-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (bad_cfg) begin
            started_d  = 1'b1;
            finished_d = 1'b1;
            state_d    = ST_EXH;
          end else if (restart_i || !started_q) begin
            started_d  = 1'b1;
            finished_d = 1'b0;
            idx_d      = '0;
            state_d    = ST_LOAD;
          end else if (finished_q) begin
            state_d = ST_EXH;
          end else begin
            idx_d   = k_last;
            state_d = ST_SCAN;
          end
        end
      end
      ST_LOAD: begin
        wr.we = 1'b1;
        if (idx_q == k_last) begin
          idx_d   = '0;
          state_d = ST_EMIT;
        end else begin
          idx_d = idx_q + cen_pkg::IDX_BITS'(1);
        end
      end
      ST_SCAN: begin
        if (alu_below) begin
          wr.we = 1'b1;
          run_d = alu_inc;
          if (idx_q == k_last) begin
            idx_d   = '0;
            state_d = ST_EMIT;
          end else begin
            idx_d   = idx_q + cen_pkg::IDX_BITS'(1);
            state_d = ST_FILL;
          end
        end else if (idx_q == '0) begin
          finished_d = 1'b1;
          state_d    = ST_EXH;
        end else begin
          idx_d = idx_q - cen_pkg::IDX_BITS'(1);
        end
      end
      ST_FILL: begin
        wr.we = 1'b1;
        run_d = alu_inc;
        if (idx_q == k_last) begin
          idx_d   = '0;
          state_d = ST_EMIT;
        end else begin
          idx_d = idx_q + cen_pkg::IDX_BITS'(1);
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          element_d   = rd_data;
          last_d      = (idx_q == k_last);
          exh_d       = 1'b0;
          if (idx_q == k_last) begin
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + cen_pkg::IDX_BITS'(1);
          end
        end
      end
      ST_EXH: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          element_d   = '0;
          last_d      = 1'b1;
          exh_d       = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      run_q        <= '0;
      started_q    <= 1'b0;
      finished_q   <= 1'b0;
      set_size_q   <= cen_pkg::SET_SIZE_RST;
      pick_count_q <= cen_pkg::PICK_COUNT_RST;
      out_valid_q  <= 1'b0;
      element_q    <= '0;
      last_q       <= 1'b0;
      exh_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      run_q        <= run_d;
      started_q    <= started_d;
      finished_q   <= finished_d;
      set_size_q   <= set_size_d;
      pick_count_q <= pick_count_d;
      out_valid_q  <= out_valid_d;
      element_q    <= element_d;
      last_q       <= last_d;
      exh_q        <= exh_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign element_o      = element_q;
  assign last_element_o = last_q;
  assign exhausted_o    = exh_q;

  // exhausted transaction is a single zero element marked last
  `CEN_ASSERT_IMP(a_exh_shape, clk_i, rst_ni, out_valid_q && exh_q, last_q && (element_q == '0))
  // busy right after a request transaction
  `CEN_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, in_accept, !in_ready_o)
  // emit index never runs past the last position
  `CEN_ASSERT_IMP(a_emit_idx, clk_i, rst_ni, state_q == ST_EMIT, idx_q <= k_last)
  // store writes only in load, scan and fill steps
  `CEN_ASSERT_IMP(a_wr_state, clk_i, rst_ni, wr.we,
                  (state_q == ST_LOAD) || (state_q == ST_SCAN) || (state_q == ST_FILL))

endmodule

`default_nettype wire
